[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge, off during reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// same check, also active during reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

[rtl/jov_pkg.sv]
// ----------------------------------------------------------------------------
// jov_pkg
// types, constants and helpers of the json object validator
// ----------------------------------------------------------------------------
package jov_pkg;

   localparam int MaxNestDefault = 32;
   localparam logic [4:0] DepthLimitReset = 5'd16;

   localparam logic [15:0] HighSurLo = 16'hd800;
   localparam logic [15:0] HighSurHi = 16'hdbff;
   localparam logic [15:0] LowSurLo  = 16'hdc00;
   localparam logic [15:0] LowSurHi  = 16'hdfff;

   // literal table index: true at 0, false at 4, null at 9
   localparam logic [3:0] LitTrue   = 4'd1;
   localparam logic [3:0] LitFalse  = 4'd5;
   localparam logic [3:0] LitNull   = 4'd10;
   localparam logic [3:0] LitEndT   = 4'd3;
   localparam logic [3:0] LitEndF   = 4'd8;
   localparam logic [3:0] LitEndN   = 4'd12;
   localparam logic [3:0] LitLen    = 4'd13;

   typedef enum logic [4:0] {
      M_LEAD      = 5'd0,
      M_OBJ_OPEN  = 5'd1,
      M_ARR_OPEN  = 5'd2,
      M_KEY_NEXT  = 5'd3,
      M_COLON     = 5'd4,
      M_VALUE     = 5'd5,
      M_AFTER     = 5'd6,
      M_DONE      = 5'd7,
      M_LIT       = 5'd8,
      M_N_SIGN    = 5'd9,
      M_N_ZERO    = 5'd10,
      M_N_INT     = 5'd11,
      M_N_DOT     = 5'd12,
      M_N_FRAC    = 5'd13,
      M_N_EXP     = 5'd14,
      M_N_EXPSIGN = 5'd15,
      M_N_EXPD    = 5'd16,
      M_VSTR_BODY = 5'd17,
      M_VSTR_ESC  = 5'd18,
      M_VSTR_HEX  = 5'd19,
      M_VSTR_SBS  = 5'd20,
      M_VSTR_SU   = 5'd21,
      M_KSTR_BODY = 5'd22,
      M_KSTR_ESC  = 5'd23,
      M_KSTR_HEX  = 5'd24,
      M_KSTR_SBS  = 5'd25,
      M_KSTR_SU   = 5'd26
   } mode_type;

   function automatic logic [7:0] lit_char(logic [3:0] idx);
      logic [7:0] ch;
      unique case (idx)
         4'd0:  ch = 8'h74;
         4'd1:  ch = 8'h72;
         4'd2:  ch = 8'h75;
         4'd3:  ch = 8'h65;
         4'd4:  ch = 8'h66;
         4'd5:  ch = 8'h61;
         4'd6:  ch = 8'h6c;
         4'd7:  ch = 8'h73;
         4'd8:  ch = 8'h65;
         4'd9:  ch = 8'h6e;
         4'd10: ch = 8'h75;
         4'd11: ch = 8'h6c;
         4'd12: ch = 8'h6c;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // bit 4 set when the byte is not a hex digit
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      else r = 5'b10000;
      return r;
   endfunction

endpackage

[rtl/json_object_validator.sv]
// ----------------------------------------------------------------------------
// json_object_validator
// byte-at-a-time json syntax checker for a document holding one object
// ----------------------------------------------------------------------------
// channel   dir   handshake             payload
// req       in    req_valid/req_stall   req_text_byte, req_final_byte
// rsp       out   rsp_valid/rsp_stall   rsp_accepted
// csr       in    csr_write_enable      csr_write_data (depth limit)
//
// one byte transaction per cycle when req_stall is low, parse state updates on accept
// the verdict of a document is in the result register in the cycle after its last byte
// req_stall is high only while a verdict waits and rsp_stall holds it
// reset (synchronous) clears the parse state and sets the depth limit to 16
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_object_validator #(
   parameter int MAX_NEST = jov_pkg::MaxNestDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   input  logic       csr_write_enable,
   input  logic [4:0] csr_write_data
);

   // nest count holds 0..MAX_NEST, kind index covers 0..MAX_NEST-1
   localparam int NW = $clog2(MAX_NEST + 1);
   localparam int IW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   typedef struct packed {
      jov_pkg::mode_type mode;
      logic [NW-1:0]     nest;
      logic [15:0]       hex;
      logic [2:0]        cnt;
      logic              hsp;
      logic [3:0]        lit;
      logic              err;
   } state_type;

   typedef struct packed {
      state_type     st;
      logic          refeed;   // number ended, look at the byte again
      logic          wr_en;    // container opened
      logic          wr_obj;
      logic [NW-1:0] wr_lvl;
   } step_type;

   localparam state_type StateReset = '{mode: jov_pkg::M_LEAD, nest: '0, hex: '0,
                                        cnt: '0, hsp: 1'b0, lit: '0, err: 1'b0};

   state_type           st_ff, st_in;
   logic [MAX_NEST-1:0] kinds_ff;
   logic [4:0]          limit_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_acc_ff, rsp_acc_in;
   logic                req_take;
   logic                kind_top;
   logic [NW-1:0]       nest_m1;
   step_type            p1, p2, pf;

   // mode after a complete value at the given nesting
   function automatic jov_pkg::mode_type finish_mode(logic [NW-1:0] nest);
      return (nest != '0) ? jov_pkg::M_AFTER : jov_pkg::M_DONE;
   endfunction

   function automatic step_type open_cont(step_type r, logic obj);
      step_type o;
      o = r;
      if (r.st.nest >= NW'(MAX_NEST)) begin
         o.st.err = 1'b1;
      end else begin
         o.wr_en   = 1'b1;
         o.wr_obj  = obj;
         o.wr_lvl  = r.st.nest;
         o.st.nest = r.st.nest + 1'b1;
         o.st.mode = obj ? jov_pkg::M_OBJ_OPEN : jov_pkg::M_ARR_OPEN;
      end
      return o;
   endfunction

   function automatic step_type close_cont(step_type r);
      step_type o;
      o = r;
      if (r.st.nest != '0) o.st.nest = r.st.nest - 1'b1;
      o.st.mode = finish_mode(o.st.nest);
      return o;
   endfunction

   function automatic step_type start_value(step_type r, logic [7:0] c, logic [4:0] lim);
      step_type o;
      o = r;
      if (int'(r.st.nest) > int'(lim)) begin
         o.st.err = 1'b1;
      end else begin
         priority if (c == 8'h22) o.st.mode = jov_pkg::M_VSTR_BODY;
         else if (c == 8'h7b) o = open_cont(r, 1'b1);
         else if (c == 8'h5b) o = open_cont(r, 1'b0);
         else if (c == 8'h74) begin
            o.st.lit = jov_pkg::LitTrue;  o.st.mode = jov_pkg::M_LIT;
         end else if (c == 8'h66) begin
            o.st.lit = jov_pkg::LitFalse; o.st.mode = jov_pkg::M_LIT;
         end else if (c == 8'h6e) begin
            o.st.lit = jov_pkg::LitNull;  o.st.mode = jov_pkg::M_LIT;
         end else if (c == 8'h2d) o.st.mode = jov_pkg::M_N_SIGN;
         else if (c == 8'h30) o.st.mode = jov_pkg::M_N_ZERO;
         else if (c >= 8'h31 && c <= 8'h39) o.st.mode = jov_pkg::M_N_INT;
         else o.st.err = 1'b1;
      end
      return o;
   endfunction

   function automatic step_type feed(state_type s, logic [7:0] c, logic ktop,
                                     logic [4:0] lim);
      step_type r;
      logic ws, dig, key, ee;
      logic [4:0] hd;
      logic [15:0] hv;
      logic [2:0] cn;
      r = '{st: s, refeed: 1'b0, wr_en: 1'b0, wr_obj: 1'b0, wr_lvl: '0};
      ws  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
      dig = (c >= 8'h30) && (c <= 8'h39);
      ee  = (c == 8'h65) || (c == 8'h45);
      key = (s.mode >= jov_pkg::M_KSTR_BODY);
      hd  = jov_pkg::hex_nibble(c);
      hv  = {s.hex[11:0], hd[3:0]};
      cn  = s.cnt + 1'b1;
      unique case (s.mode)
         jov_pkg::M_VSTR_BODY, jov_pkg::M_KSTR_BODY: begin
            if (c == 8'h22) r.st.mode = key ? jov_pkg::M_COLON : finish_mode(s.nest);
            else if (c < 8'h20) r.st.err = 1'b1;
            else if (c == 8'h5c) r.st.mode = key ? jov_pkg::M_KSTR_ESC : jov_pkg::M_VSTR_ESC;
         end
         jov_pkg::M_VSTR_ESC, jov_pkg::M_KSTR_ESC: begin
            if (c == 8'h22 || c == 8'h5c || c == 8'h2f || c == 8'h62 || c == 8'h66 ||
                c == 8'h6e || c == 8'h72 || c == 8'h74) begin
               r.st.mode = key ? jov_pkg::M_KSTR_BODY : jov_pkg::M_VSTR_BODY;
            end else if (c == 8'h75) begin
               r.st.hex  = '0;
               r.st.cnt  = '0;
               r.st.hsp  = 1'b0;
               r.st.mode = key ? jov_pkg::M_KSTR_HEX : jov_pkg::M_VSTR_HEX;
            end else r.st.err = 1'b1;
         end
         jov_pkg::M_VSTR_HEX, jov_pkg::M_KSTR_HEX: begin
            if (hd[4]) begin
               r.st.err = 1'b1;
            end else begin
               r.st.hex = hv;
               r.st.cnt = cn;
               if (cn == 3'd4) begin
                  if (s.hsp) begin
                     if (hv >= jov_pkg::LowSurLo && hv <= jov_pkg::LowSurHi) begin
                        r.st.hsp  = 1'b0;
                        r.st.mode = key ? jov_pkg::M_KSTR_BODY : jov_pkg::M_VSTR_BODY;
                     end else r.st.err = 1'b1;
                  end else if (hv == 16'h0000) begin
                     r.st.err = 1'b1;
                  end else if (hv >= jov_pkg::HighSurLo && hv <= jov_pkg::HighSurHi) begin
                     r.st.hsp  = 1'b1;
                     r.st.mode = key ? jov_pkg::M_KSTR_SBS : jov_pkg::M_VSTR_SBS;
                  end else if (hv >= jov_pkg::LowSurLo && hv <= jov_pkg::LowSurHi) begin
                     r.st.err = 1'b1;
                  end else r.st.mode = key ? jov_pkg::M_KSTR_BODY : jov_pkg::M_VSTR_BODY;
               end
            end
         end
         jov_pkg::M_VSTR_SBS, jov_pkg::M_KSTR_SBS: begin
            if (c == 8'h5c) r.st.mode = key ? jov_pkg::M_KSTR_SU : jov_pkg::M_VSTR_SU;
            else r.st.err = 1'b1;
         end
         jov_pkg::M_VSTR_SU, jov_pkg::M_KSTR_SU: begin
            if (c == 8'h75) begin
               r.st.hex  = '0;
               r.st.cnt  = '0;
               r.st.mode = key ? jov_pkg::M_KSTR_HEX : jov_pkg::M_VSTR_HEX;
            end else r.st.err = 1'b1;
         end
         jov_pkg::M_LEAD: begin
            if (!ws) begin
               if (c == 8'h7b) r = open_cont(r, 1'b1);
               else r.st.err = 1'b1;
            end
         end
         jov_pkg::M_OBJ_OPEN: begin
            if (!ws) begin
               if (c == 8'h7d) r = close_cont(r);
               else if (c == 8'h22) r.st.mode = jov_pkg::M_KSTR_BODY;
               else r.st.err = 1'b1;
            end
         end
         jov_pkg::M_ARR_OPEN: begin
            if (!ws) begin
               if (c == 8'h5d) r = close_cont(r);
               else r = start_value(r, c, lim);
            end
         end
         jov_pkg::M_KEY_NEXT: begin
            if (!ws) begin
               if (c == 8'h22) r.st.mode = jov_pkg::M_KSTR_BODY;
               else r.st.err = 1'b1;
            end
         end
         jov_pkg::M_COLON: begin
            if (!ws) begin
               if (c == 8'h3a) r.st.mode = jov_pkg::M_VALUE;
               else r.st.err = 1'b1;
            end
         end
         jov_pkg::M_VALUE: begin
            if (!ws) r = start_value(r, c, lim);
         end
         jov_pkg::M_AFTER: begin
            // kind of the innermost open container, object when set
            if (!ws) begin
               if (c == 8'h2c) r.st.mode = ktop ? jov_pkg::M_KEY_NEXT : jov_pkg::M_VALUE;
               else if (c == (ktop ? 8'h7d : 8'h5d)) r = close_cont(r);
               else r.st.err = 1'b1;
            end
         end
         jov_pkg::M_DONE: begin
            if (!ws) r.st.err = 1'b1;
         end
         jov_pkg::M_LIT: begin
            if (s.lit >= jov_pkg::LitLen || c != jov_pkg::lit_char(s.lit)) begin
               r.st.err = 1'b1;
            end else if (s.lit == jov_pkg::LitEndT || s.lit == jov_pkg::LitEndF ||
                         s.lit == jov_pkg::LitEndN) begin
               r.st.mode = finish_mode(s.nest);
            end else r.st.lit = s.lit + 1'b1;
         end
         jov_pkg::M_N_SIGN: begin
            if (c == 8'h30) r.st.mode = jov_pkg::M_N_ZERO;
            else if (dig) r.st.mode = jov_pkg::M_N_INT;
            else r.st.err = 1'b1;
         end
         jov_pkg::M_N_ZERO, jov_pkg::M_N_INT: begin
            if (!(s.mode == jov_pkg::M_N_INT && dig)) begin
               if (c == 8'h2e) r.st.mode = jov_pkg::M_N_DOT;
               else if (ee) r.st.mode = jov_pkg::M_N_EXP;
               else begin
                  r.st.mode = finish_mode(s.nest);
                  r.refeed  = 1'b1;
               end
            end
         end
         jov_pkg::M_N_DOT: begin
            if (dig) r.st.mode = jov_pkg::M_N_FRAC;
            else r.st.err = 1'b1;
         end
         jov_pkg::M_N_FRAC: begin
            if (!dig) begin
               if (ee) r.st.mode = jov_pkg::M_N_EXP;
               else begin
                  r.st.mode = finish_mode(s.nest);
                  r.refeed  = 1'b1;
               end
            end
         end
         jov_pkg::M_N_EXP: begin
            if (c == 8'h2b || c == 8'h2d) r.st.mode = jov_pkg::M_N_EXPSIGN;
            else if (dig) r.st.mode = jov_pkg::M_N_EXPD;
            else r.st.err = 1'b1;
         end
         jov_pkg::M_N_EXPSIGN: begin
            if (dig) r.st.mode = jov_pkg::M_N_EXPD;
            else r.st.err = 1'b1;
         end
         jov_pkg::M_N_EXPD: begin
            if (!dig) begin
               r.st.mode = finish_mode(s.nest);
               r.refeed  = 1'b1;
            end
         end
         default: r.st.err = 1'b1;
      endcase
      return r;
   endfunction

   // the output register parts the two sides, a waiting verdict blocks only when held
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // innermost container kind; ending a number never changes the nesting before the recheck
   assign nest_m1  = st_ff.nest - 1'b1;
   assign kind_top = (st_ff.nest != '0) && kinds_ff[nest_m1[IW-1:0]];

   always_comb begin
      p1 = feed(st_ff, req_text_byte, kind_top, limit_ff);
      p2 = feed(p1.st, req_text_byte, kind_top, limit_ff);
      // sticky error: once set the byte is not looked at
      if (st_ff.err) begin
         pf = '{st: st_ff, refeed: 1'b0, wr_en: 1'b0, wr_obj: 1'b0, wr_lvl: '0};
      end else if (p1.refeed && !p1.st.err) begin
         pf = p2;
      end else begin
         pf = p1;
      end
   end

   always_comb begin
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      if (req_take) begin
         st_in = pf.st;
         if (req_final_byte) begin
            // verdict out, parse state back to its reset value
            rsp_valid_in = 1'b1;
            rsp_acc_in   = !pf.st.err && (pf.st.mode == jov_pkg::M_DONE);
            st_in        = StateReset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= StateReset;
         limit_ff     <= jov_pkg::DepthLimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) limit_ff <= csr_write_data;
      end
   end

   // payload registers, no reset needed: kinds are read only below the nest count
   always_ff @(posedge clock) begin
      rsp_acc_ff <= rsp_acc_in;
      if (req_take && pf.wr_en) kinds_ff[pf.wr_lvl[IW-1:0]] <= pf.wr_obj;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;

   // a held verdict stays put
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted))
   // the last byte of a document always yields a verdict
   `ASSERT_CLK(a_final_rsp, clock, reset, req_take && req_final_byte |=> rsp_valid)
   // nesting never passes the stack size
   `ASSERT_ALWAYS(a_nest_cap, clock, reset || (int'(st_ff.nest) <= MAX_NEST))
   // before the opening brace nothing is open
   `ASSERT_CLK(a_lead_empty, clock, reset, st_ff.mode == jov_pkg::M_LEAD |-> st_ff.nest == '0)

endmodule
